FILE: hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Types, constants and round functions shared by the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int BLK_BITS  = 512;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       message_end;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word_0;
    logic [63:0] digest_word_1;
    logic [63:0] digest_word_2;
    logic [63:0] digest_word_3;
  } out_item_t;

  // one padded message block handed from front to back
  typedef struct packed {
    logic                last;   // final block of a message
    logic [BLK_BITS-1:0] data;   // byte 0 in the top bits
  } blk_t;

  function automatic logic [31:0] h_init(input logic [2:0] i);
    logic [31:0] r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      3'd7: r = 32'h5be0cd19;
      default: r = 32'h6a09e667;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] t);
    logic [31:0] r;
    case (t)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
      default: r = 32'h428a2f98;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] ror(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

endpackage

FILE: hdl/shs_front.sv
// ----------------------------------------------------------------------------
// shs_front
// Takes bytes, builds 64-byte blocks in a shift line and appends padding.
// ----------------------------------------------------------------------------
module shs_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  shs_pkg::in_item_t in_data,
  input  logic             q_full,
  output logic             q_push,
  output shs_pkg::blk_t    q_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_P80  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_LEN  = 2'd3;

  logic [1:0]                   st_r, st_nxt;
  logic [5:0]                   fill_r, fill_nxt;
  logic [63:0]                  bits_r, bits_nxt;
  logic [shs_pkg::BLK_BITS-1:0] blk_r, blk_nxt;

  logic       accept;
  logic       pad_go;
  logic       shift_en;
  logic [7:0] shift_byte;
  logic [2:0] len_idx;
  logic [5:0] len_sh;
  logic [63:0] len_shifted;
  logic       fill_last;

  assign in_stall  = (st_r != ST_IDLE) | q_full;
  assign accept    = in_valid & ~in_stall;
  assign pad_go    = (st_r != ST_IDLE) & ~q_full;
  assign shift_en  = (accept & in_data.byte_present) | pad_go;
  assign fill_last = (fill_r == 6'd63);

  // length bytes sit at block bytes 56..63, most significant first
  assign len_idx     = fill_r[2:0];
  assign len_sh      = {~len_idx, 3'b000};
  assign len_shifted = bits_r >> len_sh;

  always_comb begin
    case (st_r)
      ST_IDLE: shift_byte = in_data.data_byte;
      ST_P80:  shift_byte = 8'h80;
      ST_ZERO: shift_byte = 8'h00;
      ST_LEN:  shift_byte = len_shifted[7:0];
      default: shift_byte = 8'h00;
    endcase
  end

  assign q_push       = shift_en & fill_last;
  assign q_wdata.data = {blk_r[shs_pkg::BLK_BITS-9:0], shift_byte};
  assign q_wdata.last = (st_r == ST_LEN);

  always_comb begin
    blk_nxt  = shift_en ? {blk_r[shs_pkg::BLK_BITS-9:0], shift_byte} : blk_r;
    fill_nxt = shift_en ? fill_r + 6'd1 : fill_r;
    bits_nxt = bits_r;
    st_nxt   = st_r;
    if (accept & in_data.byte_present) begin
      bits_nxt = bits_r + 64'd8;
    end
    case (st_r)
      ST_IDLE: begin
        if (accept & in_data.message_end) begin
          st_nxt = ST_P80;
        end
      end
      ST_P80: begin
        if (pad_go) begin
          st_nxt = (fill_r == 6'd55) ? ST_LEN : ST_ZERO;
        end
      end
      ST_ZERO: begin
        if (pad_go && fill_r == 6'd55) begin
          st_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        if (pad_go && fill_last) begin
          st_nxt   = ST_IDLE;
          bits_nxt = 64'd0;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      fill_r <= 6'd0;
      bits_r <= 64'd0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      bits_r <= bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

`ifndef SYNTHESIS
  // length phase only ever covers the last eight bytes of a block
  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_LEN) |-> (fill_r >= 6'd56))
    else $error("length phase outside block tail");

  // a final block is pushed only from the length phase and ends padding
  a_last_push: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && q_wdata.last) |=> (st_r == ST_IDLE && fill_r == 6'd0 && bits_r == 64'd0))
    else $error("padding did not close after final block");

  // no input is taken while padding runs
  a_pad_block: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> in_stall)
    else $error("input taken during padding");
`endif

endmodule

FILE: hdl/shs_queue.sv
// ----------------------------------------------------------------------------
// shs_queue
// Short block queue between front and back.
// ----------------------------------------------------------------------------
module shs_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  shs_pkg::blk_t wdata,
  output logic          full,
  input  logic          pop,
  output logic          rvalid,
  output shs_pkg::blk_t rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  shs_pkg::blk_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full   = (cnt_r == CW'(DEPTH));
  assign rvalid = (cnt_r != '0);
  assign rdata  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rvalid)
    else $error("queue underflow");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

FILE: hdl/shs_back.sv
// ----------------------------------------------------------------------------
// shs_back
// Compression engine: one round per cycle, then chaining update and digest.
// ----------------------------------------------------------------------------
module shs_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  shs_pkg::blk_t     q_rdata,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output shs_pkg::out_item_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [5:0]  round_r;
  logic        last_r;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic        out_valid_r;
  shs_pkg::out_item_t out_data_r;

  logic [31:0] t1, t2, w_new;
  logic [31:0] sum [8];
  logic        out_free;
  logic        fin_go;
  logic        dig_load;
  shs_pkg::out_item_t dig;

  assign out_free = ~out_valid_r | ~out_stall;
  assign q_pop    = (st_r == ST_IDLE) & q_valid;
  assign fin_go   = (st_r == ST_FIN) & (~last_r | out_free);
  assign dig_load = fin_go & last_r;

  assign t1 = v_r[7] + shs_pkg::big_s1(v_r[4])
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + shs_pkg::k_const(round_r) + w_r[0];
  assign t2 = shs_pkg::big_s0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  assign w_new = shs_pkg::small_s1(w_r[14]) + w_r[9]
               + shs_pkg::small_s0(w_r[1]) + w_r[0];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sum[i] = h_r[i] + v_r[i];
    end
    dig.digest_word_0 = {sum[0], sum[1]};
    dig.digest_word_1 = {sum[2], sum[3]};
    dig.digest_word_2 = {sum[4], sum[5]};
    dig.digest_word_3 = {sum[6], sum[7]};
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) st_nxt = ST_RUN;
      ST_RUN:  if (round_r == 6'd63) st_nxt = ST_FIN;
      ST_FIN:  if (fin_go) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      round_r     <= 6'd0;
      out_valid_r <= 1'b0;
      last_r      <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= shs_pkg::h_init(3'(i));
      end
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_RUN) begin
        round_r <= round_r + 6'd1;
      end
      if (q_pop) begin
        last_r <= q_rdata.last;
      end
      if (fin_go) begin
        for (int i = 0; i < 8; i++) begin
          h_r[i] <= last_r ? shs_pkg::h_init(3'(i)) : sum[i];
        end
      end
      if (dig_load) begin
        out_valid_r <= 1'b1;
      end else if (~out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int j = 0; j < 16; j++) begin
        w_r[j] <= q_rdata.data[shs_pkg::BLK_BITS-1-32*j -: 32];
      end
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (st_r == ST_RUN) begin
      for (int j = 0; j < 15; j++) begin
        w_r[j] <= w_r[j+1];
      end
      w_r[15] <= w_new;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (dig_load) begin
      out_data_r <= dig;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_RUN) |-> (round_r == 6'd0))
    else $error("round counter not cleared outside rounds");

  a_digest_out: assert property (@(posedge clk) disable iff (!rst_n)
    dig_load |=> out_valid)
    else $error("digest not presented after final block");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    dig_load |-> (!out_valid_r || !out_stall))
    else $error("digest overwrote a pending result");
`endif

endmodule

FILE: hdl/sha256_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_core
// SHA-256 over a byte stream; emits the 256-bit digest on each end mark.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the block queue has room and no padding runs.
// Each block passes through the compression engine as a load, 64 rounds and an update.
// An end mark holds off input while 9 to 72 padding bytes are shifted in.
// The digest is registered when the final block's chaining update runs. Reset
// (rst_n low, synchronous) empties the queue and loads the initial hash values;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core #(
  // block queue depth, 2..16
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transaction: one optional byte and an end mark
  input  logic               in_valid,
  output logic               in_stall,
  input  shs_pkg::in_item_t  in_data,
  // result transaction: digest, big-endian
  output logic               out_valid,
  input  logic               out_stall,
  output shs_pkg::out_item_t out_data
);

  // front to queue
  logic          q_push;
  logic          q_full;
  shs_pkg::blk_t q_wdata;
  // queue to back
  logic          q_pop;
  logic          q_valid;
  shs_pkg::blk_t q_rdata;

  // byte collection and padding: fills a 512-bit shift line, pushes full blocks
  shs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // decouples byte intake from the round engine
  shs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .full   (q_full),
    .pop    (q_pop),
    .rvalid (q_valid),
    .rdata  (q_rdata)
  );

  // compression, chaining update and digest output register
  shs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
